>>> rtl/cpb_pkg.sv
package cpb_pkg;

	typedef enum logic [1:0] {
		REQ_PALETTE = 2'd0,
		REQ_START   = 2'd1,
		REQ_BYTE    = 2'd2
	} req_kind_t;

	typedef enum logic {
		KIND_PIXEL = 1'b0,
		KIND_END   = 1'b1
	} res_kind_t;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_TOP   = 3'd1,
		PH_LEN   = 3'd2,
		PH_PAD_A = 3'd3,
		PH_DATA  = 3'd4,
		PH_PAD_B = 3'd5
	} phase_t;

	localparam logic [7:0]  END_MARK    = 8'hff;
	localparam logic [12:0] PITCH_RESET = 13'd320;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [19:0] column_top;
		logic [7:0]  stream_byte;
		logic [7:0]  palette_index;
		logic [15:0] palette_colour;
	} req_t;

	typedef struct packed {
		logic        out_kind;
		logic [19:0] write_address;
		logic [15:0] pixel_value;
	} res_t;

endpackage

>>> rtl/column_post_blitter.sv
// A request and its palette memory read are registered in req_s1 and rdata_s1;
// its result is then registered in res_q and shown on res. One request per
// cycle is taken unless res_stall holds a result; the parser reads s1 registers.
// Reset (arst_n, asynchronous): parser idle, counters and addresses zero,
// line pitch 320; palette contents stay undefined until written.
module column_post_blitter #(
	parameter int FRAME_ADDR_BITS = 20,
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  cpb_pkg::req_t  req,
	output logic           res_valid,
	input  logic           res_stall,
	output cpb_pkg::res_t  res,
	input  logic           cfg_write_en,
	input  logic [12:0]    cfg_write_data
);
	import cpb_pkg::*;

	localparam int IDX_BITS = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
	typedef logic [FRAME_ADDR_BITS-1:0] addr_t;

	logic [15:0] palette_mem [PALETTE_ENTRIES];

	logic        valid_s1;
	req_t        req_s1;
	logic [15:0] rdata_s1;
	logic        oor_s1;

	phase_t      phase_q, phase_d;
	logic [7:0]  post_remaining_q, post_remaining_d;
	addr_t       column_base_q, column_base_d;
	addr_t       row_address_q, row_address_d;
	logic [12:0] line_pitch_q;

	logic        res_valid_q;
	res_t        res_q, res_d;
	logic        gen;
	logic        advance;
	logic        accept;
	logic [20:0] prod;

	assign accept    = req_valid && !req_stall;
	assign advance   = valid_s1 && (!gen || !res_valid_q || !res_stall);
	assign req_stall = valid_s1 && !advance;
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign prod      = {13'b0, req_s1.stream_byte} * {8'b0, line_pitch_q};

	always_ff @(posedge clk) begin
		if (accept) begin
			if (req.req_type == REQ_PALETTE &&
			    {1'b0, req.palette_index} < 9'(PALETTE_ENTRIES)) begin
				palette_mem[req.palette_index[IDX_BITS-1:0]] <= req.palette_colour;
			end
			rdata_s1 <= palette_mem[req.stream_byte[IDX_BITS-1:0]];
			oor_s1   <= !({1'b0, req.stream_byte} < 9'(PALETTE_ENTRIES));
			req_s1   <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pitch_q <= PITCH_RESET;
		end else if (cfg_write_en) begin
			line_pitch_q <= cfg_write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			post_remaining_q <= '0;
			column_base_q    <= '0;
			row_address_q    <= '0;
		end else if (advance) begin
			phase_q          <= phase_d;
			post_remaining_q <= post_remaining_d;
			column_base_q    <= column_base_d;
			row_address_q    <= row_address_d;
		end
	end

	always_comb begin
		phase_d          = phase_q;
		post_remaining_d = post_remaining_q;
		column_base_d    = column_base_q;
		row_address_d    = row_address_q;
		gen              = 1'b0;
		res_d            = '0;
		if (valid_s1) begin
			unique case (req_s1.req_type)
				REQ_START: begin
					column_base_d    = addr_t'(req_s1.column_top);
					row_address_d    = addr_t'(req_s1.column_top);
					post_remaining_d = '0;
					phase_d          = PH_TOP;
				end
				REQ_BYTE: begin
					unique case (phase_q)
						PH_TOP: begin
							if (req_s1.stream_byte == END_MARK) begin
								phase_d        = PH_IDLE;
								gen            = 1'b1;
								res_d.out_kind = KIND_END;
							end else begin
								row_address_d = column_base_q + addr_t'(prod);
								phase_d       = PH_LEN;
							end
						end
						PH_LEN: begin
							post_remaining_d = req_s1.stream_byte;
							phase_d          = PH_PAD_A;
						end
						PH_PAD_A: begin
							phase_d = (post_remaining_q == 8'd0) ? PH_PAD_B : PH_DATA;
						end
						PH_DATA: begin
							gen                 = 1'b1;
							res_d.out_kind      = KIND_PIXEL;
							res_d.write_address = 20'(row_address_q);
							res_d.pixel_value   = oor_s1 ? 16'd0 : rdata_s1;
							row_address_d       = row_address_q + addr_t'(line_pitch_q);
							post_remaining_d    = post_remaining_q - 8'd1;
							if (post_remaining_d == 8'd0) begin
								phase_d = PH_PAD_B;
							end
						end
						PH_PAD_B: begin
							phase_d = PH_TOP;
						end
						default: begin
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (!res_valid_q || !res_stall) begin
			res_valid_q <= advance && gen;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && gen) begin
			res_q <= res_d;
		end
	end

	a_data_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> post_remaining_q != 8'd0)
		else $error("data phase with no pixels left");

	a_stall_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> valid_s1 && res_valid_q && res_stall)
		else $error("input stalled without a blocked request");

	a_start_resets_parse: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.req_type == REQ_START |=>
			phase_q == PH_TOP && post_remaining_q == 8'd0)
		else $error("column start did not reset the parser");

endmodule
